>>> rtl/core/rpcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radar pixel cleanup filter package
// Shared types, color constants, the palette table and the nearest-color
// scan order.
// ----------------------------------------------------------------------------
package rpcf_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int ROW_W         = 12;
  localparam int WIN_N         = 16;
  localparam int PAL_N         = 19;
  localparam int LANE_W        = 64;

  localparam logic [31:0] COL_OUTER    = 32'hFFA0A0A4;
  localparam logic [31:0] COL_INNER    = 32'hFFD0D0D0;
  localparam logic [31:0] COL_BOUNDARY = 32'hFF000080;
  localparam logic [31:0] COL_TRANSP   = 32'h00000000;
  localparam logic [31:0] COL_BLACK    = 32'hFF000000;

  localparam logic [31:0] PALETTE [PAL_N] = '{
    32'hFF5F0000, 32'hFFFF0000, 32'hFF884400, 32'hFFCC6600, 32'hFF009800,
    32'hFF00C25A, 32'hFF3F3F5F, 32'hFF000074, 32'hFFFF557F, 32'hFFFFAA7F,
    32'hFFFFFF80, 32'hFF46FF93, 32'hFF9CAAB1, 32'hFFC700C7, 32'hFF0138FF,
    32'hFFFF55FF, 32'hFF3E88FF, 32'hFFFFAAFF, 32'hFFA2C6FF
  };

  // Window positions (column * 4 + row) sorted by Manhattan distance from
  // the center, ties broken by column first and then row.
  localparam logic [3:0] SCAN_ORDER [WIN_N] = '{
    4'd10, 4'd6, 4'd9, 4'd11, 4'd14, 4'd2, 4'd5, 4'd7,
    4'd8, 4'd13, 4'd15, 4'd1, 4'd3, 4'd4, 4'd12, 4'd0
  };

  localparam logic [3:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_FRAME_HEIGHT = 4'd1;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1024;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1000;

  typedef struct packed {
    logic [31:0] image_pixel;
    logic [31:0] stencil_pixel;
  } pix_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic        frame_last;
  } res_t;

  typedef struct packed {
    logic pal;
    logic outer;
    logic inner;
    logic sblack;
  } flag_t;

  function automatic flag_t pixel_flags(logic [31:0] img, logic [31:0] st);
    flag_t f;
    f.pal = 1'b0;
    for (int p = 0; p < PAL_N; p++) begin
      if (img == PALETTE[p]) f.pal = 1'b1;
    end
    f.outer  = (img == COL_OUTER) || (img == COL_TRANSP);
    f.inner  = (img == COL_INNER);
    f.sblack = (st == COL_BLACK);
    return f;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rpcf_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line store
// One memory word per column holds three row slots of image and stencil
// pixels. Reads all three slots and writes the current slot; the read is registered.
// ----------------------------------------------------------------------------
module rpcf_line_store #(
  parameter int MAX_WIDTH = rpcf_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic                   wr,
  input  wire logic [AW-1:0]          addr,
  input  wire logic [1:0]             slot,
  input  wire rpcf_pkg::pix_t         wdata,
  output rpcf_pkg::pix_t [2:0]        rows
);
  import rpcf_pkg::*;

  logic [3*LANE_W-1:0] mem [MAX_WIDTH];
  logic [3*LANE_W-1:0] rd_word;
  logic [1:0]          slot_q;

  // Read-before-write: the slot being overwritten returns the row three back.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_word <= mem[addr];
      slot_q  <= slot;
      if (wr) begin
        mem[addr][LANE_W*slot +: LANE_W] <= wdata;
      end
    end
  end

  // Rotate so that rows[0] is three rows back and rows[2] the previous row.
  always_comb begin
    case (slot_q)
      2'd1: begin
        rows[0] = rd_word[LANE_W*1 +: LANE_W];
        rows[1] = rd_word[LANE_W*2 +: LANE_W];
        rows[2] = rd_word[LANE_W*0 +: LANE_W];
      end
      2'd2: begin
        rows[0] = rd_word[LANE_W*2 +: LANE_W];
        rows[1] = rd_word[LANE_W*0 +: LANE_W];
        rows[2] = rd_word[LANE_W*1 +: LANE_W];
      end
      default: begin
        rows[0] = rd_word[LANE_W*0 +: LANE_W];
        rows[1] = rd_word[LANE_W*1 +: LANE_W];
        rows[2] = rd_word[LANE_W*2 +: LANE_W];
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/rpcf_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window registers
// 4x4 image window with per-pixel classification flags, shifted one column
// per transaction. Padding columns shift in zeros.
// ----------------------------------------------------------------------------
module rpcf_window (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      shift,
  input  wire logic                      pad,
  input  wire rpcf_pkg::pix_t [2:0]      rows,
  input  wire rpcf_pkg::pix_t            cur,
  output logic [rpcf_pkg::WIN_N-1:0][31:0] img_win,
  output rpcf_pkg::flag_t [rpcf_pkg::WIN_N-1:0] flags
);
  import rpcf_pkg::*;

  pix_t  [3:0] col_pix;
  flag_t [3:0] col_flag;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (pad) begin
        col_pix[j] = '0;
      end else if (j == 3) begin
        col_pix[j] = cur;
      end else begin
        col_pix[j] = rows[j];
      end
      col_flag[j] = pixel_flags(col_pix[j].image_pixel, col_pix[j].stencil_pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_win <= '0;
      flags   <= '0;
    end else if (shift) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          img_win[i*4+j] <= img_win[(i+1)*4+j];
          flags[i*4+j]   <= flags[(i+1)*4+j];
        end
      end
      for (int j = 0; j < 4; j++) begin
        img_win[12+j] <= col_pix[j].image_pixel;
        flags[12+j]   <= col_flag[j];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rpcf_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel selection
// Decides boundary, nearest palette color or pass-through for the window
// center and holds the result in the output register.
// ----------------------------------------------------------------------------
module rpcf_select #(
  parameter int CW = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          item_valid,
  input  wire logic [CW-1:0]                 col,
  input  wire logic [rpcf_pkg::ROW_W-1:0]    row,
  input  wire logic [CW-1:0]                 wc,
  input  wire logic [rpcf_pkg::ROW_W-1:0]    hc,
  input  wire logic [rpcf_pkg::WIN_N-1:0][31:0] img_win,
  input  wire rpcf_pkg::flag_t [rpcf_pkg::WIN_N-1:0] flags,
  output logic                               res_valid,
  output rpcf_pkg::res_t                     res_data
);
  import rpcf_pkg::*;

  logic [3:0]       col_ok;
  logic [3:0]       row_ok;
  logic [WIN_N-1:0] ok;
  logic [WIN_N-1:0] cand;
  logic [CW:0]      cx;
  logic [ROW_W:0]   ry;
  logic             any_outer;
  logic             any_inner;
  logic             st_black;
  logic             kept_black;
  logic             found;
  logic [3:0]       sel;
  logic [31:0]      pixel;
  logic [CW-1:0]    x;
  logic [ROW_W-1:0] y;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cx = (CW+1)'(col) + (CW+1)'(i);
      col_ok[i] = (cx >= (CW+1)'(3)) && (cx < (CW+1)'(wc) + (CW+1)'(3));
      ry = (ROW_W+1)'(row) + (ROW_W+1)'(i);
      row_ok[i] = (ry >= (ROW_W+1)'(3)) && (ry < (ROW_W+1)'(hc) + (ROW_W+1)'(3));
    end
    for (int k = 0; k < WIN_N; k++) begin
      ok[k]   = col_ok[k/4] && row_ok[k%4];
      cand[k] = ok[k] && flags[k].pal;
    end

    any_outer = 1'b0;
    any_inner = 1'b0;
    for (int i = 1; i < 4; i++) begin
      for (int j = 1; j < 4; j++) begin
        if (!ok[i*4+j] || flags[i*4+j].outer) any_outer = 1'b1;
        if (ok[i*4+j] && flags[i*4+j].inner) any_inner = 1'b1;
      end
    end

    st_black = 1'b0;
    for (int k = 0; k < WIN_N; k++) begin
      if (ok[k] && flags[k].sblack) st_black = 1'b1;
    end
    kept_black = (img_win[10] == COL_BLACK) && !st_black;

    // Walk the scan order backward so the earliest candidate wins.
    found = 1'b0;
    sel   = SCAN_ORDER[0];
    for (int k = WIN_N - 1; k >= 0; k--) begin
      if (cand[SCAN_ORDER[k]]) begin
        found = 1'b1;
        sel   = SCAN_ORDER[k];
      end
    end

    if (any_outer && any_inner) begin
      pixel = COL_BOUNDARY;
    end else if (!flags[10].pal && !kept_black) begin
      pixel = found ? img_win[sel] : COL_TRANSP;
    end else begin
      pixel = img_win[10];
    end

    x = col - CW'(1);
    y = row - ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= item_valid && (col != '0) && (row != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.out_pixel  <= pixel;
      res_data.out_col    <= 11'(x);
      res_data.out_row    <= 11'(y);
      res_data.frame_last <= (col == wc) && (row == hc);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/radar_pixel_cleanup_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radar pixel cleanup filter
// Line-store based 4x4 window filter that cleans radar map pixels.
// ----------------------------------------------------------------------------
// Usage:
// The pix channel takes raster-order image/stencil pixel pairs, with one
// padding column after every row and one padding row after the last row,
// so a frame is (width+1)*(height+1) transactions. The res channel returns
// one cleaned pixel with its column, row and a frame_last flag for each
// transaction that completes a window; transactions in the first column or
// the first row return nothing. The cfg channel writes frame_width (index 0)
// and frame_height (index 1); cfg_ready is always high, and writes belong
// between frames.
// One transaction is taken per cycle while pix_stall is low. The transaction
// that completes a result starts the line store read when it is accepted,
// then shifts the window, and then the selection is registered into the
// output register.
// When res_stall is high with a result waiting, the whole pipeline holds and
// pix_stall rises in the same cycle. Reset clears positions, the window and
// the output valid, and loads width 1024 and height 1000; the line store
// needs no clearing.
// ----------------------------------------------------------------------------
module radar_pixel_cleanup_filter #(
  parameter int MAX_WIDTH = rpcf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pix_valid,
  output logic                pix_stall,
  input  wire rpcf_pkg::pix_t pix_data,
  output logic                res_valid,
  input  wire logic           res_stall,
  output rpcf_pkg::res_t      res_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [3:0]     cfg_index,
  input  wire logic [11:0]    cfg_data
);
  import rpcf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [11:0]      frame_width;
  logic [11:0]      frame_height;
  logic [CW-1:0]    wc;
  logic [ROW_W-1:0] hc;

  logic [CW-1:0]    col_pos, col_pos_next, c_cur;
  logic [ROW_W-1:0] row_pos, row_pos_next, r_cur;
  logic [1:0]       slot, slot_next, slot_cur;

  logic             adv;
  logic             take;
  logic             pad_cur;

  logic             s1_valid;
  logic             s1_pad;
  logic [CW-1:0]    s1_c;
  logic [ROW_W-1:0] s1_r;
  pix_t             s1_pix;

  logic             s2_valid;
  logic [CW-1:0]    s2_c;
  logic [ROW_W-1:0] s2_r;

  pix_t [2:0]              rows;
  logic [WIN_N-1:0][31:0]  img_win;
  flag_t [WIN_N-1:0]       flags;

  assign cfg_ready = 1'b1;
  assign adv       = !(res_valid && res_stall);
  assign pix_stall = !adv;
  assign take      = pix_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, oversize is clipped.
  always_comb begin
    if (frame_width == '0) begin
      wc = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wc = CW'(MAX_WIDTH);
    end else begin
      wc = CW'(frame_width);
    end
    if (frame_height == '0) begin
      hc = ROW_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      hc = ROW_W'(MAX_HEIGHT);
    end else begin
      hc = ROW_W'(frame_height);
    end
  end

  always_comb begin
    c_cur    = (col_pos > wc) ? wc : col_pos;
    r_cur    = (row_pos > hc) ? '0 : row_pos;
    slot_cur = (row_pos > hc) ? 2'd0 : slot;
    pad_cur  = (c_cur >= wc);
    if (pad_cur) begin
      col_pos_next = '0;
      if (r_cur >= hc) begin
        row_pos_next = '0;
        slot_next    = 2'd0;
      end else begin
        row_pos_next = r_cur + ROW_W'(1);
        slot_next    = (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
      end
    end else begin
      col_pos_next = c_cur + CW'(1);
      row_pos_next = r_cur;
      slot_next    = slot_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      slot     <= 2'd0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
        slot    <= slot_next;
      end
      if (adv) begin
        s1_valid <= pix_valid;
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pad <= pad_cur;
      s1_c   <= c_cur;
      s1_r   <= r_cur;
      s1_pix <= pix_data;
      s2_c   <= s1_c;
      s2_r   <= s1_r;
    end
  end

  rpcf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk   (clk),
    .en    (take),
    .wr    (!pad_cur),
    .addr  (c_cur[AW-1:0]),
    .slot  (slot_cur),
    .wdata (pix_data),
    .rows  (rows)
  );

  rpcf_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (adv && s1_valid),
    .pad     (s1_pad),
    .rows    (rows),
    .cur     (s1_pix),
    .img_win (img_win),
    .flags   (flags)
  );

  rpcf_select #(
    .CW (CW)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (s2_valid),
    .col        (s2_c),
    .row        (s2_r),
    .wc         (wc),
    .hc         (hc),
    .img_win    (img_win),
    .flags      (flags),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv && s2_valid && (s2_c != '0) && (s2_r != '0) |=> res_valid)
    else $error("completed window produced no result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s2_valid) && $stable(s2_c) && $stable(s2_r) && $stable(s1_valid))
    else $error("pipeline moved while output stalled");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.frame_last |->
      (res_data.out_col == 11'(wc - CW'(1))) && (res_data.out_row == 11'(hc - ROW_W'(1))))
    else $error("frame_last on a pixel other than the last one");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    pix_stall |=> $stable(col_pos) && $stable(row_pos))
    else $error("position advanced without a transaction");
`endif

endmodule
`default_nettype wire

>>> tb/sv/pixel_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel cleanup scoreboard
// Watches the pixel, result and register channels of the cleanup filter,
// predicts each cleaned pixel from its own copy of the line stores and
// window, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module pixel_scoreboard (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  input  logic           pix_stall,
  input  rpcf_pkg::pix_t pix_data,
  input  logic           res_valid,
  input  logic           res_stall,
  input  rpcf_pkg::res_t res_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [3:0]     cfg_index,
  input  logic [11:0]    cfg_data,
  output int             errors,
  output int             pending
);
  import rpcf_pkg::*;

  localparam int LS_W = 2048;

  logic [11:0] width_reg, height_reg;
  logic [31:0] img_rows [3*LS_W];
  logic [31:0] sten_rows [3*LS_W];
  logic [31:0] img_win [4][4];
  logic [31:0] sten_win [4][4];
  int unsigned col_pos, row_pos;
  res_t cleaned_q [$];

  function automatic bit is_palette(logic [31:0] p);
    for (int i = 0; i < PAL_N; i++) begin
      if (PALETTE[i] == p) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the window by one transaction and queues the pixel it completes.
  task automatic clean_pixel(pix_t t);
    int unsigned w, h, c, r, slot, k;
    int n_outer, n_inner, best, d;
    bit ok [4][4];
    bit sten_black, keep_black;
    logic [31:0] center, pick;
    res_t e;
    w = (width_reg == 0) ? 1 : (width_reg > LS_W) ? LS_W : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (col_pos > w) col_pos = w;
    if (row_pos > h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    slot = r % 3;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        img_win[i][j] = img_win[i+1][j];
        sten_win[i][j] = sten_win[i+1][j];
      end
    end
    if (c < w) begin
      for (int j = 0; j < 3; j++) begin
        k = ((slot + j) % 3) * LS_W + c;
        img_win[3][j] = img_rows[k];
        sten_win[3][j] = sten_rows[k];
      end
      img_win[3][3] = t.image_pixel;
      sten_win[3][3] = t.stencil_pixel;
      img_rows[slot*LS_W + c] = t.image_pixel;
      sten_rows[slot*LS_W + c] = t.stencil_pixel;
    end else begin
      for (int j = 0; j < 4; j++) begin
        img_win[3][j] = '0;
        sten_win[3][j] = '0;
      end
    end
    if (c >= 1 && r >= 1) begin
      n_outer = 0;
      n_inner = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          ok[i][j] = (int'(c) - 3 + i >= 0) && (int'(c) - 3 + i < int'(w)) &&
                     (int'(r) - 3 + j >= 0) && (int'(r) - 3 + j < int'(h));
        end
      end
      center = img_win[2][2];
      for (int i = 1; i < 4; i++) begin
        for (int j = 1; j < 4; j++) begin
          if (!ok[i][j] || img_win[i][j] == COL_OUTER || img_win[i][j] == COL_TRANSP)
            n_outer++;
          if (ok[i][j] && img_win[i][j] == COL_INNER) n_inner++;
        end
      end
      if (n_outer > 0 && n_inner > 0) begin
        pick = COL_BOUNDARY;
      end else begin
        sten_black = 1'b0;
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            if (ok[i][j] && sten_win[i][j] == COL_BLACK) sten_black = 1'b1;
          end
        end
        keep_black = (center == COL_BLACK) && !sten_black;
        if (!is_palette(center) && !keep_black) begin
          best = 10;
          pick = COL_TRANSP;
          for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
              d = (i > 2 ? i - 2 : 2 - i) + (j > 2 ? j - 2 : 2 - j);
              if (ok[i][j] && is_palette(img_win[i][j]) && d < best) begin
                best = d;
                pick = img_win[i][j];
              end
            end
          end
        end else begin
          pick = center;
        end
      end
      e.out_pixel = pick;
      e.out_col = 11'(c - 1);
      e.out_row = 11'(r - 1);
      e.frame_last = (c - 1 == w - 1) && (r - 1 == h - 1);
      cleaned_q = {cleaned_q, e};
    end
    if (c >= w) begin
      col_pos = 0;
      row_pos = (r >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          img_win[i][j] = '0;
          sten_win[i][j] = '0;
        end
      end
      // Entries that were never written are only read at masked positions.
      for (int k = 0; k < 3*LS_W; k++) begin
        img_rows[k] = '0;
        sten_rows[k] = '0;
      end
      cleaned_q.delete();
    end else begin
      // A transaction in the same cycle as a register write sees the old value.
      if (pix_valid && !pix_stall) clean_pixel(pix_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (res_valid && !res_stall) begin
        if (cleaned_q.size() == 0) begin
          $error("unexpected result transaction: %h", res_data);
          errors++;
        end else begin
          e = cleaned_q.pop_front();
          if (res_data.out_pixel !== e.out_pixel) begin
            $error("out_pixel expected %h actual %h", e.out_pixel, res_data.out_pixel);
            errors++;
          end
          if (res_data.out_col !== e.out_col) begin
            $error("out_col expected %0d actual %0d", e.out_col, res_data.out_col);
            errors++;
          end
          if (res_data.out_row !== e.out_row) begin
            $error("out_row expected %0d actual %0d", e.out_row, res_data.out_row);
            errors++;
          end
          if (res_data.frame_last !== e.frame_last) begin
            $error("frame_last expected %0b actual %0b", e.frame_last,
                   res_data.frame_last);
            errors++;
          end
        end
      end
    end
    pending = cleaned_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar pixel cleanup filter testbench
// Sends whole padded frames over a range of frame sizes, with random gaps
// and result stalls, and lets the scoreboard check every cleaned pixel.
// ----------------------------------------------------------------------------
module testbench;
  import rpcf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  pix_t        pix_data = '0;
  logic        res_valid;
  logic        res_stall = 1'b1;
  res_t        res_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  int          errors, pending;

  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit res_took = 1'b0;
  int items_sent = 0;

  always #4 clk = ~clk;

  radar_pixel_cleanup_filter DUT (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_scoreboard scoreboard (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) res_took <= res_valid && !res_stall;

  // Result side: a random stall after each transaction, or a long hold-off.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold = 400;
        hold_req = 1'b0;
      end else if (res_took && hold == 0 && !steady) begin
        hold = $urandom_range(0, 12);
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PALETTE[$urandom_range(0, PAL_N - 1)];
      4: return COL_OUTER;
      5: return COL_INNER;
      6: return COL_TRANSP;
      7: return COL_BLACK;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(pix_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_data <= t;
    do @(posedge clk); while (pix_stall);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One padded frame; the last column and the last row carry junk data.
  task automatic run_frame(int w_set, int h_set);
    int w, h;
    pix_t t;
    w = (w_set == 0) ? 1 : (w_set > 2048) ? 2048 : w_set;
    h = (h_set == 0) ? 1 : (h_set > 2048) ? 2048 : h_set;
    write_reg(CFG_FRAME_WIDTH, 12'(w_set));
    write_reg(CFG_FRAME_HEIGHT, 12'(h_set));
    for (int r = 0; r <= h; r++) begin
      for (int c = 0; c <= w; c++) begin
        if (c == w || r == h) begin
          t.image_pixel = $urandom();
          t.stencil_pixel = $urandom();
        end else begin
          t.image_pixel = pick_color();
          t.stencil_pixel = ($urandom_range(0, 3) == 0) ? COL_BLACK :
                            ($urandom_range(0, 1) ? pick_color() : $urandom());
        end
        send_pixel(t);
      end
    end
    drain();
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Unknown indexes must be ignored.
    write_reg(4'd2, 12'hFFF);
    write_reg(4'd15, 12'h000);
    run_frame(3, 3);
    run_frame(1, 1);
    run_frame(0, 0);
    run_frame(2, 1);

    // Random frames, mostly small, some without any idling.
    n = 0;
    while (items_sent < 1000) begin
      steady = ($urandom_range(0, 3) == 0);
      if (n == 3) begin
        steady = 1'b1;
        hold_req = 1'b1;
      end
      run_frame($urandom_range(1, 12), $urandom_range(1, 8));
      n++;
    end

    // A wider frame without idling, then one more with idling.
    steady = 1'b1;
    run_frame(60, 2);
    steady = 1'b0;
    run_frame(5, 4);

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
